FILE: hw/rtl/rvsc_pkg.sv
// Shared types, constants and helper functions of the regulator voltage selector codec.
`default_nettype none

package rvsc_pkg;

  // Depth of the voltage table and the address width that indexes it.
  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int UV_PER_MV = 1000;
  localparam int MV_SAT    = 16383;

  // Microvolts to millivolts: drop three bits, then multiply by the reciprocal of 125.
  // The product is exact for every 21-bit operand.
  localparam int UV_PRE_SH   = 3;
  localparam int MV_RECIP    = 2147484;
  localparam int MV_RECIP_SH = 28;

  // Configuration port address width: eight word registers.
  localparam int CFG_AW = 5;

  // Step divider sizes.
  localparam int DIV_W  = 14;
  localparam int DVS_W  = 10;
  localparam int DIV_CW = $clog2(DIV_W);

  typedef enum logic [2:0] {
    CFG_MIN_MV    = 3'd0,
    CFG_MAX_MV    = 3'd1,
    CFG_STEP_MV   = 3'd2,
    CFG_SPLIT     = 3'd3,
    CFG_FIELD_MSK = 3'd4,
    CFG_TBL_MODE  = 3'd5,
    CFG_VREG_PRES = 3'd6,
    CFG_EN_MASK   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    REQ_SET_V  = 3'd0,
    REQ_GET_V  = 3'd1,
    REQ_SET_EN = 3'd2,
    REQ_GET_EN = 3'd3,
    REQ_LOAD   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_VREG = 2'd1,
    ST_RANGE   = 2'd2
  } stat_e;

  typedef struct packed {
    logic [13:0] min_millivolts;
    logic [13:0] max_millivolts;
    logic [9:0]  step_millivolts;
    logic [7:0]  split_point;
    logic [7:0]  voltage_field_mask;
    logic        table_mode;
    logic        voltage_reg_present;
    logic [7:0]  enable_bits_mask;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [23:0] target_microvolts;
    logic [7:0]  current_reg_byte;
    logic        enable_request;
    logic [7:0]  table_index;
    logic [13:0] table_millivolts;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  new_reg_byte;
    logic [7:0]  selector_value;
    logic [23:0] voltage_microvolts;
    logic        is_enabled;
  } res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_NOREG,
    OP_DIV_MV,
    OP_RANGE_FAIL,
    OP_DIV_SEL,
    OP_LIN_FIN,
    OP_TBL_INIT,
    OP_TBL_DEC,
    OP_TBL_FIN,
    OP_GET_DEC,
    OP_GET_TBLV,
    OP_GET_MUL,
    OP_GET_ADD,
    OP_GET_OUT,
    OP_SIMPLE
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RANGE,
    S_DIV_SEL,
    S_LIN_FIN,
    S_TBL_CMP,
    S_GET_TBL,
    S_GET_MUL,
    S_GET_ADD,
    S_GET_OUT,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       table_mode;
    logic       vreg_present;
    logic       div_done;
    logic       range_ok;
    logic       tbl_stop;
  } st_t;

  // Position of the lowest set bit of the field mask; zero for an empty mask.
  function automatic logic [2:0] field_shift(logic [7:0] m);
    logic [2:0] s;
    s = '0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) s = 3'(i);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/regulator_voltage_selector_codec.sv
// Top level of the regulator voltage selector codec.
// A request is taken when start is high and busy is low, and its single result appears
// on result_o for exactly one cycle with done_o high; the receiver cannot hold it off.
// A linear set-voltage request waits on the one-bit-per-cycle 14-bit divider that
// counts linear steps; microvolts become millivolts through a reciprocal multiply.
// A table set-voltage request compares one table entry per cycle while the search
// walks down from the top selector, through the single registered read port of the
// table. Busy stays high until the result is out, so a new request is taken only
// after the last one has finished.
// Configuration writes through the APB port take effect at once and are meant for idle time.
`default_nettype none

module regulator_voltage_selector_codec import rvsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              done_o,
  output res_t              result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  st_t  st;

  rvsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rvsc_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .st_o   (st),
    .res_o  (result_o)
  );

  rvsc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .st_i   (st),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/rvsc_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module rvsc_regs import rvsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_e'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        CFG_MIN_MV:    cfg_d.min_millivolts      = pwdata[13:0];
        CFG_MAX_MV:    cfg_d.max_millivolts      = pwdata[13:0];
        CFG_STEP_MV:   cfg_d.step_millivolts     = pwdata[9:0];
        CFG_SPLIT:     cfg_d.split_point         = pwdata[7:0];
        CFG_FIELD_MSK: cfg_d.voltage_field_mask  = pwdata[7:0];
        CFG_TBL_MODE:  cfg_d.table_mode          = pwdata[0];
        CFG_VREG_PRES: cfg_d.voltage_reg_present = pwdata[0];
        CFG_EN_MASK:   cfg_d.enable_bits_mask    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_MIN_MV:    prdata = 32'(cfg_q.min_millivolts);
      CFG_MAX_MV:    prdata = 32'(cfg_q.max_millivolts);
      CFG_STEP_MV:   prdata = 32'(cfg_q.step_millivolts);
      CFG_SPLIT:     prdata = 32'(cfg_q.split_point);
      CFG_FIELD_MSK: prdata = 32'(cfg_q.voltage_field_mask);
      CFG_TBL_MODE:  prdata = 32'(cfg_q.table_mode);
      CFG_VREG_PRES: prdata = 32'(cfg_q.voltage_reg_present);
      CFG_EN_MASK:   prdata = 32'(cfg_q.enable_bits_mask);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_millivolts      <= 14'd0;
      cfg_q.max_millivolts      <= 14'd16383;
      cfg_q.step_millivolts     <= 10'd10;
      cfg_q.split_point         <= 8'd255;
      cfg_q.voltage_field_mask  <= 8'd127;
      cfg_q.table_mode          <= 1'b0;
      cfg_q.voltage_reg_present <= 1'b1;
      cfg_q.enable_bits_mask    <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rvsc_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module rvsc_div import rvsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam logic [DIV_CW-1:0] LastCnt = DIV_CW'(DIV_W - 1);

  logic              busy_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W:0]    trial;
  logic              fits;

  // The quotient register shifts the dividend out at the top as the quotient enters below.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DVS_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_q <= trial[DVS_W-1:0];
      end
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o     = busy_q && (cnt_q == LastCnt);
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rvsc_dpath.sv
// Datapath: request registers, voltage table memory, arithmetic and result register.
`default_nettype none

module rvsc_dpath import rvsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output st_t  st_o,
  output res_t res_o
);

  localparam logic [8:0] TblLast  = 9'(TABLE_DEPTH - 1);
  localparam logic [8:0] TblDepth = 9'(TABLE_DEPTH);

  req_t        item_q;
  logic [14:0] mvu_q;
  logic [13:0] mv_q;
  logic [7:0]  sel_q;
  logic        sel_ok_q;
  logic [18:0] prod_q;
  logic [13:0] mvg_q;
  logic [13:0] rd_data_q;
  res_t        res_q, res_d;

  logic [13:0] tbl_mem [TABLE_DEPTH];

  logic [7:0]       mask, fmax, em, dec_sel, tbl_start, rd_idx;
  logic [2:0]       shift;
  logic [9:0]       step_eff;
  logic             div_start, div_done;
  logic [DIV_W-1:0] dividend, quotient;
  logic [DVS_W-1:0] divisor;
  logic [20:0]      uv_hi;
  logic [42:0]      mv_prod;
  logic [14:0]      mv_full, mv_diff;
  logic [13:0]      lin_q, split14, lin_s;
  logic [7:0]       lin_sel;
  logic [8:0]       get_s;
  logic [19:0]      get_sum;
  logic [7:0]       en_byte;
  logic             tbl_we;

  function automatic logic [7:0] merge_field(logic [7:0] cur, logic [7:0] m,
                                             logic [7:0] sel, logic [2:0] sh);
    return (cur & ~m) | ((sel << sh) & m);
  endfunction

  assign mask      = cfg_i.voltage_field_mask;
  assign shift     = field_shift(mask);
  assign fmax      = mask >> shift;
  assign em        = cfg_i.enable_bits_mask;
  assign step_eff  = (cfg_i.step_millivolts == '0) ? 10'd1 : cfg_i.step_millivolts;
  assign dec_sel   = (item_q.current_reg_byte & mask) >> shift;
  assign tbl_start = ({1'b0, fmax} > TblLast) ? TblLast[7:0] : fmax;

  // Microvolts become millivolts through a reciprocal multiply; the divider counts steps.
  assign uv_hi     = item_q.target_microvolts[23:UV_PRE_SH];
  assign mv_prod   = 43'(uv_hi) * 43'(MV_RECIP);
  assign mv_full   = mvu_q;
  assign mv_diff   = mv_full - {1'b0, cfg_i.min_millivolts};
  assign div_start = (cmd_i.op == OP_DIV_SEL);
  assign dividend  = mv_diff[DIV_W-1:0];
  assign divisor   = step_eff;

  rvsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Selectors above the split point count two steps each.
  assign lin_q   = quotient;
  assign split14 = 14'(cfg_i.split_point);
  assign lin_s   = (lin_q > split14) ? (split14 + ((lin_q - split14) >> 1)) : lin_q;
  assign lin_sel = (lin_s > 14'(fmax)) ? fmax : lin_s[7:0];

  assign get_s   = (sel_q > cfg_i.split_point) ?
                   (9'(cfg_i.split_point) + {sel_q - cfg_i.split_point, 1'b0}) : 9'(sel_q);
  assign get_sum = 20'(cfg_i.min_millivolts) + 20'(prod_q);

  assign en_byte = (item_q.current_reg_byte & ~em) | (item_q.enable_request ? em : 8'd0);

  always_comb begin
    unique case (cmd_i.op)
      OP_TBL_INIT: rd_idx = tbl_start;
      OP_TBL_DEC:  rd_idx = sel_q - 8'd1;
      OP_GET_DEC:  rd_idx = dec_sel;
      default:     rd_idx = sel_q;
    endcase
  end

  assign tbl_we = (cmd_i.op == OP_SIMPLE) && (item_q.req_type == REQ_LOAD) &&
                  ({1'b0, item_q.table_index} < TblDepth);

  always_comb begin
    res_d = res_q;
    unique case (cmd_i.op)
      OP_NOREG, OP_RANGE_FAIL: begin
        res_d              = '0;
        res_d.status       = (cmd_i.op == OP_NOREG) ? ST_NO_VREG : ST_RANGE;
        res_d.new_reg_byte = item_q.current_reg_byte;
      end
      OP_LIN_FIN: begin
        res_d                = '0;
        res_d.status         = ST_OK;
        res_d.selector_value = lin_sel;
        res_d.new_reg_byte   = merge_field(item_q.current_reg_byte, mask, lin_sel, shift);
      end
      OP_TBL_FIN: begin
        res_d                = '0;
        res_d.status         = ST_OK;
        res_d.selector_value = sel_q;
        res_d.new_reg_byte   = merge_field(item_q.current_reg_byte, mask, sel_q, shift);
      end
      OP_GET_OUT: begin
        res_d                    = '0;
        res_d.status             = ST_OK;
        res_d.new_reg_byte       = item_q.current_reg_byte;
        res_d.selector_value     = sel_q;
        res_d.voltage_microvolts = 24'(mvg_q) * 24'(UV_PER_MV);
      end
      OP_SIMPLE: begin
        res_d = '0;
        priority if (item_q.req_type == REQ_SET_EN) begin
          res_d.new_reg_byte = en_byte;
          res_d.is_enabled   = ((en_byte & em) == em);
        end else if (item_q.req_type == REQ_GET_EN) begin
          res_d.new_reg_byte = item_q.current_reg_byte;
          res_d.is_enabled   = ((item_q.current_reg_byte & em) == em);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      item_q <= req_i;
    end
    if (cmd_i.op == OP_DIV_MV) begin
      mvu_q <= mv_prod[42:MV_RECIP_SH];
    end
    if ((cmd_i.op == OP_TBL_INIT) || (cmd_i.op == OP_DIV_SEL)) begin
      mv_q <= mv_full[13:0];
    end
    unique case (cmd_i.op)
      OP_TBL_INIT: sel_q <= tbl_start;
      OP_TBL_DEC:  sel_q <= sel_q - 8'd1;
      OP_GET_DEC:  sel_q <= dec_sel;
      default: ;
    endcase
    if (cmd_i.op == OP_GET_DEC) begin
      sel_ok_q <= ({1'b0, dec_sel} < TblDepth);
    end
    if (cmd_i.op == OP_GET_MUL) begin
      prod_q <= 19'(get_s) * 19'(cfg_i.step_millivolts);
    end
    if (cmd_i.op == OP_GET_ADD) begin
      mvg_q <= (get_sum > 20'(MV_SAT)) ? 14'(MV_SAT) : get_sum[13:0];
    end else if (cmd_i.op == OP_GET_TBLV) begin
      mvg_q <= sel_ok_q ? rd_data_q : 14'd0;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[item_q.table_index[TBL_AW-1:0]] <= item_q.table_millivolts;
    end
    rd_data_q <= tbl_mem[rd_idx[TBL_AW-1:0]];
  end

  assign st_o.req_type     = item_q.req_type;
  assign st_o.table_mode   = cfg_i.table_mode;
  assign st_o.vreg_present = cfg_i.voltage_reg_present;
  assign st_o.div_done     = div_done;
  assign st_o.range_ok     = !(mv_full < {1'b0, cfg_i.min_millivolts}) &&
                             !(mv_full > {1'b0, cfg_i.max_millivolts});
  assign st_o.tbl_stop     = (sel_q == 8'd0) || !(rd_data_q > mv_q);

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rvsc_ctrl.sv
// Controller state machine that sequences the datapath for each request.
`default_nettype none

module rvsc_ctrl import rvsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  st_t  st_i,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    busy      = (state_q != S_IDLE);
    done_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (st_i.req_type == REQ_SET_V) begin
          if (!st_i.vreg_present) begin
            cmd_o.op = OP_NOREG;
            state_d  = S_DONE;
          end else begin
            cmd_o.op = OP_DIV_MV;
            state_d  = S_RANGE;
          end
        end else if (st_i.req_type == REQ_GET_V) begin
          if (!st_i.vreg_present) begin
            cmd_o.op = OP_NOREG;
            state_d  = S_DONE;
          end else begin
            cmd_o.op = OP_GET_DEC;
            state_d  = st_i.table_mode ? S_GET_TBL : S_GET_MUL;
          end
        end else begin
          cmd_o.op = OP_SIMPLE;
          state_d  = S_DONE;
        end
      end
      S_RANGE: begin
        priority if (!st_i.range_ok) begin
          cmd_o.op = OP_RANGE_FAIL;
          state_d  = S_DONE;
        end else if (st_i.table_mode) begin
          cmd_o.op = OP_TBL_INIT;
          state_d  = S_TBL_CMP;
        end else begin
          cmd_o.op = OP_DIV_SEL;
          state_d  = S_DIV_SEL;
        end
      end
      S_DIV_SEL: begin
        if (st_i.div_done) state_d = S_LIN_FIN;
      end
      S_LIN_FIN: begin
        cmd_o.op = OP_LIN_FIN;
        state_d  = S_DONE;
      end
      // One table entry is compared per cycle while the search walks downward.
      S_TBL_CMP: begin
        if (st_i.tbl_stop) begin
          cmd_o.op = OP_TBL_FIN;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_TBL_DEC;
        end
      end
      S_GET_TBL: begin
        cmd_o.op = OP_GET_TBLV;
        state_d  = S_GET_OUT;
      end
      S_GET_MUL: begin
        cmd_o.op = OP_GET_MUL;
        state_d  = S_GET_ADD;
      end
      S_GET_ADD: begin
        cmd_o.op = OP_GET_ADD;
        state_d  = S_GET_OUT;
      end
      S_GET_OUT: begin
        cmd_o.op = OP_GET_OUT;
        state_d  = S_DONE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("controller not busy after an accepted request");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_search_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TBL_CMP && st_i.tbl_stop) |=> (state_q == S_DONE))
    else $error("table search did not finish on its stop condition");

endmodule

`default_nettype wire

FILE: verif/regulator_voltage_selector_codec_tb.sv
// Self-checking testbench for the regulator voltage selector codec: directed table, then random phases.
module regulator_voltage_selector_codec_tb;
  import rvsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 20;

  localparam logic [2:0] REQ_FIRST_UNKNOWN = 3'd5;
  localparam logic [2:0] REQ_LAST_CODE     = 3'd7;

  typedef enum bit {ROW_REQ, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    reg_idx;
    logic [31:0] reg_val;
    req_t        item;
    bit          pinned;
    res_t        exp;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  req_t              req_i;
  logic              done_o;
  res_t              result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Register and table copies used to work out each expected result.
  cfg_t        cfg_mirror;
  logic [13:0] volt_table_mv [TABLE_DEPTH];
  // Table as the sender sees it, so that no request reads an entry never loaded.
  logic [13:0] sent_table_mv [TABLE_DEPTH];
  bit          sent_written  [TABLE_DEPTH];

  res_t        pending_results [$];
  bit          pin_next;
  res_t        pinned_result;
  int          err_count;
  int          quiet_cycles;

  regulator_voltage_selector_codec DUT (.*);

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int unsigned mask_lsb(int unsigned mask);
    int unsigned s;
    s = 0;
    if (mask == 0) return 0;
    while (((mask >> s) & 1) == 0) s++;
    return s;
  endfunction

  function automatic res_t predict_result(req_t r);
    res_t        res;
    int unsigned mask, shift, fmax, mv, sel, step, em, cur, nb;
    res   = '0;
    cur   = r.current_reg_byte;
    mask  = cfg_mirror.voltage_field_mask;
    shift = mask_lsb(mask);
    fmax  = mask >> shift;
    em    = cfg_mirror.enable_bits_mask;
    case (r.req_type)
      REQ_SET_V: begin
        res.new_reg_byte = 8'(cur);
        mv = r.target_microvolts / UV_PER_MV;
        if (!cfg_mirror.voltage_reg_present) begin
          res.status = ST_NO_VREG;
        end else if (mv < cfg_mirror.min_millivolts || mv > cfg_mirror.max_millivolts) begin
          res.status = ST_RANGE;
        end else begin
          if (cfg_mirror.table_mode) begin
            // Walk down from the top selector to the first entry not above the target.
            sel = fmax;
            while (sel != 0 && volt_table_mv[sel] > mv) sel--;
          end else begin
            step = (cfg_mirror.step_millivolts == 0) ? 1 : cfg_mirror.step_millivolts;
            sel  = (mv - cfg_mirror.min_millivolts) / step;
            if (sel > cfg_mirror.split_point)
              sel = cfg_mirror.split_point + (sel - cfg_mirror.split_point) / 2;
            if (sel > fmax) sel = fmax;
          end
          res.selector_value = 8'(sel);
          res.new_reg_byte   = 8'((cur & ~mask) | ((sel << shift) & mask));
        end
      end
      REQ_GET_V: begin
        res.new_reg_byte = 8'(cur);
        if (!cfg_mirror.voltage_reg_present) begin
          res.status = ST_NO_VREG;
        end else begin
          sel = (cur & mask) >> shift;
          if (cfg_mirror.table_mode) begin
            mv = volt_table_mv[sel];
          end else begin
            step = sel;
            if (step > cfg_mirror.split_point)
              step = cfg_mirror.split_point + (step - cfg_mirror.split_point) * 2;
            mv = cfg_mirror.min_millivolts + step * cfg_mirror.step_millivolts;
          end
          if (mv > MV_SAT) mv = MV_SAT;
          res.selector_value     = 8'(sel);
          res.voltage_microvolts = 24'(mv * UV_PER_MV);
        end
      end
      REQ_SET_EN: begin
        nb = (cur & ~em) | (r.enable_request ? em : 0);
        res.new_reg_byte = 8'(nb);
        res.is_enabled   = ((nb & em) == em);
      end
      REQ_GET_EN: begin
        res.new_reg_byte = 8'(cur);
        res.is_enabled   = ((cur & em) == em);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Index of the first table entry this request would read before it is loaded, else -1.
  function automatic int first_unwritten_read(req_t r);
    int unsigned mask, shift, sel, mv;
    if (!cfg_mirror.table_mode || !cfg_mirror.voltage_reg_present) return -1;
    mask  = cfg_mirror.voltage_field_mask;
    shift = mask_lsb(mask);
    if (r.req_type == REQ_GET_V) begin
      sel = (r.current_reg_byte & mask) >> shift;
      return sent_written[sel] ? -1 : int'(sel);
    end
    if (r.req_type != REQ_SET_V) return -1;
    mv = r.target_microvolts / UV_PER_MV;
    if (mv < cfg_mirror.min_millivolts || mv > cfg_mirror.max_millivolts) return -1;
    sel = mask >> shift;
    while (sel != 0) begin
      if (!sent_written[sel]) return int'(sel);
      if (sent_table_mv[sel] <= mv) break;
      sel--;
    end
    return -1;
  endfunction

  function automatic req_t random_bits_req();
    return req_t'($bits(req_t)'({$urandom(), $urandom()}));
  endfunction

  function automatic logic [13:0] rising_entry_mv(int unsigned idx);
    return 14'(idx * 64 + $urandom_range(0, 63));
  endfunction

  function automatic req_t make_random_item();
    req_t        r;
    int unsigned pick, mv, lo, hi;
    r    = random_bits_req();
    pick = $urandom_range(0, 99);
    lo   = cfg_mirror.min_millivolts;
    hi   = cfg_mirror.max_millivolts;
    if (pick < 38) begin
      r.req_type = REQ_SET_V;
      pick = $urandom_range(0, 9);
      if (pick < 6 && lo <= hi) begin
        mv = $urandom_range(lo, hi);
        r.target_microvolts = 24'(mv * UV_PER_MV + $urandom_range(0, 999));
      end else if (pick < 8) begin
        case ($urandom_range(0, 3))
          0: r.target_microvolts = 24'(lo * UV_PER_MV);
          1: r.target_microvolts = 24'(hi * UV_PER_MV + 999);
          2: r.target_microvolts = 24'((hi + 1) * UV_PER_MV);
          default: r.target_microvolts = (lo == 0) ? '0 : 24'(lo * UV_PER_MV - 1);
        endcase
      end
    end else if (pick < 58) begin
      r.req_type = REQ_GET_V;
    end else if (pick < 68) begin
      r.req_type = REQ_SET_EN;
    end else if (pick < 78) begin
      r.req_type = REQ_GET_EN;
    end else if (pick < 94) begin
      r.req_type = REQ_LOAD;
      if ($urandom_range(0, 4) != 0) r.table_millivolts = rising_entry_mv(r.table_index);
    end else begin
      r.req_type = 3'($urandom_range(REQ_FIRST_UNKNOWN, REQ_LAST_CODE));
    end
    return r;
  endfunction

  function automatic cfg_t make_random_cfg();
    cfg_t        c;
    int unsigned w, pos;
    c.min_millivolts  = ($urandom_range(0, 9) == 0) ? 14'($urandom()) : 14'($urandom_range(0, 1500));
    c.max_millivolts  = ($urandom_range(0, 3) == 0) ? 14'h3FFF
                        : 14'(((c.min_millivolts + $urandom_range(0, 3000)) > MV_SAT) ? MV_SAT
                              : (c.min_millivolts + $urandom_range(0, 3000)));
    if ($urandom_range(0, 9) == 0) c.max_millivolts = 14'($urandom());
    c.step_millivolts = ($urandom_range(0, 9) == 0) ? 10'($urandom()) : 10'($urandom_range(1, 50));
    c.split_point     = 8'($urandom());
    case ($urandom_range(0, 9))
      8: c.voltage_field_mask = 8'($urandom());
      9: c.voltage_field_mask = 8'h00;
      default: begin
        w   = $urandom_range(1, 8);
        pos = $urandom_range(0, 8 - w);
        c.voltage_field_mask = 8'(((1 << w) - 1) << pos);
      end
    endcase
    c.table_mode          = ($urandom_range(0, 4) < 2);
    c.voltage_reg_present = ($urandom_range(0, 7) != 0);
    c.enable_bits_mask    = 8'($urandom());
    return c;
  endfunction

  function automatic logic [31:0] reg_value(cfg_idx_e idx);
    case (idx)
      CFG_MIN_MV:    return 32'(cfg_mirror.min_millivolts);
      CFG_MAX_MV:    return 32'(cfg_mirror.max_millivolts);
      CFG_STEP_MV:   return 32'(cfg_mirror.step_millivolts);
      CFG_SPLIT:     return 32'(cfg_mirror.split_point);
      CFG_FIELD_MSK: return 32'(cfg_mirror.voltage_field_mask);
      CFG_TBL_MODE:  return 32'(cfg_mirror.table_mode);
      CFG_VREG_PRES: return 32'(cfg_mirror.voltage_reg_present);
      default:       return 32'(cfg_mirror.enable_bits_mask);
    endcase
  endfunction

  function automatic dir_row_t req_row(logic [2:0] code, int unsigned uv, int unsigned cur,
                                       bit en, int unsigned idx, int unsigned mv);
    dir_row_t row;
    row.kind    = ROW_REQ;
    row.reg_idx = CFG_MIN_MV;
    row.reg_val = '0;
    row.pinned  = 1'b0;
    row.exp     = '0;
    row.item.req_type          = code;
    row.item.target_microvolts = 24'(uv);
    row.item.current_reg_byte  = 8'(cur);
    row.item.enable_request    = en;
    row.item.table_index       = 8'(idx);
    row.item.table_millivolts  = 14'(mv);
    return row;
  endfunction

  // Expected result typed in by hand: selector and decoded voltage are zero in all of these.
  function automatic dir_row_t pin_row(dir_row_t row, stat_e st, int unsigned nb, bit ena);
    row.pinned           = 1'b1;
    row.exp              = '0;
    row.exp.status       = st;
    row.exp.new_reg_byte = 8'(nb);
    row.exp.is_enabled   = ena;
    return row;
  endfunction

  function automatic dir_row_t reg_row(cfg_idx_e idx, int unsigned val);
    dir_row_t row;
    row         = req_row(REQ_GET_EN, 0, 0, 1'b0, 0, 0);
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = 32'(val);
    return row;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  task automatic apb_access(input bit wr, input cfg_idx_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop sending and wait until every expected result has been seen.
  task automatic settle_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic program_reg(cfg_idx_e idx, logic [31:0] val);
    logic [31:0] rd;
    settle_idle();
    apb_access(1'b1, idx, val, rd);
    case (idx)
      CFG_MIN_MV:    cfg_mirror.min_millivolts      = val[13:0];
      CFG_MAX_MV:    cfg_mirror.max_millivolts      = val[13:0];
      CFG_STEP_MV:   cfg_mirror.step_millivolts     = val[9:0];
      CFG_SPLIT:     cfg_mirror.split_point         = val[7:0];
      CFG_FIELD_MSK: cfg_mirror.voltage_field_mask  = val[7:0];
      CFG_TBL_MODE:  cfg_mirror.table_mode          = val[0];
      CFG_VREG_PRES: cfg_mirror.voltage_reg_present = val[0];
      default:       cfg_mirror.enable_bits_mask    = val[7:0];
    endcase
    apb_access(1'b0, idx, '0, rd);
    check_field({idx.name(), " readback"}, reg_value(idx), rd);
  endtask

  task automatic apply_config(cfg_t c);
    program_reg(CFG_MIN_MV,    32'(c.min_millivolts));
    program_reg(CFG_MAX_MV,    32'(c.max_millivolts));
    program_reg(CFG_STEP_MV,   32'(c.step_millivolts));
    program_reg(CFG_SPLIT,     32'(c.split_point));
    program_reg(CFG_FIELD_MSK, 32'(c.voltage_field_mask));
    program_reg(CFG_TBL_MODE,  32'(c.table_mode));
    program_reg(CFG_VREG_PRES, 32'(c.voltage_reg_present));
    program_reg(CFG_EN_MASK,   32'(c.enable_bits_mask));
  endtask

  // Present one request and hold it until the block takes it.
  task automatic send_item(req_t r, bit pin, res_t exp);
    @(negedge clk_i);
    start         <= 1'b1;
    req_i         <= r;
    pin_next      = pin;
    pinned_result = exp;
    if (r.req_type == REQ_LOAD) begin
      sent_table_mv[r.table_index] = r.table_millivolts;
      sent_written[r.table_index]  = 1'b1;
    end
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic pause_sender(int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    start <= 1'b0;
    req_i <= random_bits_req();
    repeat (n - 1) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, result_o.status);
          check_field("new_reg_byte", want.new_reg_byte, result_o.new_reg_byte);
          check_field("selector_value", want.selector_value, result_o.selector_value);
          check_field("voltage_microvolts", want.voltage_microvolts,
                      result_o.voltage_microvolts);
          check_field("is_enabled", want.is_enabled, result_o.is_enabled);
        end
      end
      if (start && !busy) begin
        pending_results.push_back(pin_next ? pinned_result : predict_result(req_i));
        if (req_i.req_type == REQ_LOAD) volt_table_mv[req_i.table_index] = req_i.table_millivolts;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t    directed_rows [$];
    cfg_t        fixed_cfgs [4];
    cfg_t        phase_cfg;
    req_t        r;
    int          hole;
    int unsigned burst_left;

    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pin_next      = 1'b0;
    pinned_result = '0;
    err_count     = 0;
    quiet_cycles  = 0;
    burst_left    = 0;
    cfg_mirror    = '{min_millivolts: 14'd0, max_millivolts: 14'h3FFF, step_millivolts: 10'd10,
                      split_point: 8'hFF, voltage_field_mask: 8'h7F, table_mode: 1'b0,
                      voltage_reg_present: 1'b1, enable_bits_mask: 8'h01};
    foreach (sent_written[i]) begin
      sent_written[i]  = 1'b0;
      sent_table_mv[i] = '0;
      volt_table_mv[i] = '0;
    end

    fixed_cfgs[0] = '{min_millivolts: 14'd0, max_millivolts: 14'h3FFF, step_millivolts: 10'd1,
                      split_point: 8'd0, voltage_field_mask: 8'hFF, table_mode: 1'b0,
                      voltage_reg_present: 1'b1, enable_bits_mask: 8'hFF};
    fixed_cfgs[1] = '{min_millivolts: 14'h3FFF, max_millivolts: 14'h3FFF,
                      step_millivolts: 10'h3FF, split_point: 8'hFF, voltage_field_mask: 8'h80,
                      table_mode: 1'b0, voltage_reg_present: 1'b1, enable_bits_mask: 8'h00};
    fixed_cfgs[2] = '{min_millivolts: 14'd0, max_millivolts: 14'h3FFF, step_millivolts: 10'd0,
                      split_point: 8'hFF, voltage_field_mask: 8'hFF, table_mode: 1'b1,
                      voltage_reg_present: 1'b1, enable_bits_mask: 8'h01};
    fixed_cfgs[3] = '{min_millivolts: 14'd100, max_millivolts: 14'd0, step_millivolts: 10'd5,
                      split_point: 8'd128, voltage_field_mask: 8'h00, table_mode: 1'b0,
                      voltage_reg_present: 1'b0, enable_bits_mask: 8'h80};

    // Directed part; the first rows run on the reset values of the registers.
    directed_rows.push_back(pin_row(req_row(REQ_GET_EN, 0, 'hFF, 0, 0, 0), ST_OK, 'hFF, 1));
    directed_rows.push_back(pin_row(req_row(REQ_SET_EN, 0, 'h00, 1, 0, 0), ST_OK, 'h01, 1));
    directed_rows.push_back(pin_row(req_row(REQ_SET_EN, 0, 'hFF, 0, 0, 0), ST_OK, 'hFE, 0));
    directed_rows.push_back(pin_row(req_row(REQ_GET_V, 0, 'h00, 0, 0, 0), ST_OK, 'h00, 0));
    directed_rows.push_back(req_row(REQ_GET_V, 0, 'hFF, 1, 'hFF, 'h3FFF));
    directed_rows.push_back(pin_row(req_row(REQ_SET_V, 'hFFFFFF, 'hA5, 1, 'hFF, 'h3FFF),
                                    ST_RANGE, 'hA5, 0));
    directed_rows.push_back(pin_row(req_row(REQ_SET_V, 0, 'hFF, 0, 0, 0), ST_OK, 'h80, 0));
    // Selector far above the field maximum.
    directed_rows.push_back(req_row(REQ_SET_V, 16383999, 'h00, 0, 0, 0));
    directed_rows.push_back(pin_row(req_row(REQ_LAST_CODE, 'hFFFFFF, 'hFF, 1, 'hFF, 'h3FFF),
                                    ST_OK, 0, 0));
    directed_rows.push_back(pin_row(req_row(REQ_LOAD, 0, 0, 0, 'hFF, 'h3FFF), ST_OK, 0, 0));
    directed_rows.push_back(pin_row(req_row(REQ_LOAD, 0, 0, 0, 0, 0), ST_OK, 0, 0));
    directed_rows.push_back(req_row(REQ_LOAD, 0, 0, 0, 1, 1000));
    directed_rows.push_back(req_row(REQ_LOAD, 0, 0, 0, 2, 2000));
    directed_rows.push_back(req_row(REQ_LOAD, 0, 0, 0, 3, 3000));
    directed_rows.push_back(reg_row(CFG_FIELD_MSK, 'h0C));
    directed_rows.push_back(reg_row(CFG_TBL_MODE, 1));
    directed_rows.push_back(req_row(REQ_SET_V, 2500000, 'hFF, 0, 0, 0));
    // Search runs all the way down to selector zero.
    directed_rows.push_back(req_row(REQ_SET_V, 0, 'h00, 0, 0, 0));
    directed_rows.push_back(req_row(REQ_GET_V, 0, 'h0C, 0, 0, 0));
    directed_rows.push_back(reg_row(CFG_VREG_PRES, 0));
    directed_rows.push_back(pin_row(req_row(REQ_SET_V, 1000, 'h5A, 0, 0, 0), ST_NO_VREG, 'h5A, 0));
    directed_rows.push_back(pin_row(req_row(REQ_GET_V, 0, 'h5A, 0, 0, 0), ST_NO_VREG, 'h5A, 0));
    directed_rows.push_back(reg_row(CFG_VREG_PRES, 1));
    directed_rows.push_back(reg_row(CFG_TBL_MODE, 0));
    directed_rows.push_back(reg_row(CFG_FIELD_MSK, 0));
    directed_rows.push_back(reg_row(CFG_STEP_MV, 0));
    directed_rows.push_back(reg_row(CFG_MIN_MV, 'h3FFF));
    // Empty field mask with a zero step.
    directed_rows.push_back(req_row(REQ_GET_V, 0, 'hFF, 0, 0, 0));
    directed_rows.push_back(req_row(REQ_SET_V, 16383500, 'hFF, 0, 0, 0));
    directed_rows.push_back(reg_row(CFG_FIELD_MSK, 'hFF));
    directed_rows.push_back(reg_row(CFG_STEP_MV, 'h3FF));
    directed_rows.push_back(reg_row(CFG_SPLIT, 0));
    // Decoded voltage far above the top of the range saturates.
    directed_rows.push_back(req_row(REQ_GET_V, 0, 'hFF, 0, 0, 0));
    directed_rows.push_back(reg_row(CFG_MIN_MV, 0));
    directed_rows.push_back(reg_row(CFG_STEP_MV, 0));
    directed_rows.push_back(req_row(REQ_SET_V, 200000, 'h00, 0, 0, 0));
    directed_rows.push_back(reg_row(CFG_EN_MASK, 'hFF));
    directed_rows.push_back(pin_row(req_row(REQ_GET_EN, 0, 'h7F, 0, 0, 0), ST_OK, 'h7F, 0));
    directed_rows.push_back(reg_row(CFG_EN_MASK, 0));
    directed_rows.push_back(pin_row(req_row(REQ_SET_EN, 0, 'h3C, 0, 0, 0), ST_OK, 'h3C, 1));
    directed_rows.push_back(reg_row(CFG_MAX_MV, 0));
    directed_rows.push_back(pin_row(req_row(REQ_SET_V, 1000, 'hFF, 0, 0, 0), ST_RANGE, 'hFF, 0));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG)
        program_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].exp);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_cfg = (p < 4) ? fixed_cfgs[p] : make_random_cfg();
      apply_config(phase_cfg);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Every third phase sends back to back; the others send in bursts.
        if (p % 3 != 2 && burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8));
        end
        if (burst_left != 0) burst_left--;
        r    = make_random_item();
        hole = first_unwritten_read(r);
        if (hole >= 0) begin
          r.req_type         = REQ_LOAD;
          r.table_index      = 8'(hole);
          r.table_millivolts = rising_entry_mv(hole);
        end
        send_item(r, 1'b0, '0);
      end
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
